[design/sks_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types, codes and widths for the sorted key table search block.
// ----------------------------------------------------------------------------
package sks_pkg;

   localparam int KEY_CHARS_DEF   = 6;
   localparam int VALUE_CHARS_DEF = 8;
   localparam int TABLE_DEPTH_DEF = 64;

   localparam int KEY_W    = 48;
   localparam int VALUE_W  = 64;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_SORT   = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH,
      S_SORT_OUTER,
      S_SORT_RD,
      S_SORT_CMP,
      S_SORT_SWAP_A,
      S_SORT_SWAP_B,
      S_SRCH_STEP,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_SRCH_CHK_R,
      S_SRCH_CHK_L,
      S_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load_req;
      logic push_wr;
      logic sort_init;
      logic sort_outer;
      logic sort_rd_j;
      logic sort_cmp;
      logic swap_rd;
      logic swap_wr;
      logic mark_sorted;
      logic srch_init;
      logic srch_rd_mid;
      logic srch_cmp;
      logic srch_rd_r;
      logic srch_rd_l;
      logic srch_hit;
      logic srch_miss;
      logic set_status_full;
      logic set_status_bad;
      logic resp_load;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            full;
      logic            empty;
      logic            bad_key;
      logic            outer_done;
      logic            inner_done;
      logic            srch_done;
      logic            rd_match;
   } sts_type;

endpackage
`default_nettype wire

[design/sks_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sks_ctrl
// Sequencer for push, selection sort and binary search over the table.
// ----------------------------------------------------------------------------
module sks_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire logic            rsp_tready,
   input  wire sks_pkg::sts_type sts,
   output sks_pkg::cmd_type      cmd
);

   sks_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sks_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sks_pkg::S_IDLE: begin
            if (req_tvalid) begin
               unique case (sts.op)
                  sks_pkg::OP_PUSH:   state_in = sks_pkg::S_PUSH;
                  sks_pkg::OP_SORT:   state_in = sks_pkg::S_SORT_OUTER;
                  sks_pkg::OP_SEARCH: state_in = sks_pkg::S_SRCH_STEP;
                  default:            state_in = sks_pkg::S_RESP;
               endcase
            end
         end
         sks_pkg::S_PUSH:       state_in = sks_pkg::S_RESP;
         sks_pkg::S_SORT_OUTER:
            state_in = sts.outer_done ? sks_pkg::S_RESP : sks_pkg::S_SORT_RD;
         sks_pkg::S_SORT_RD:    state_in = sks_pkg::S_SORT_CMP;
         sks_pkg::S_SORT_CMP:
            state_in = sts.inner_done ? sks_pkg::S_SORT_SWAP_A : sks_pkg::S_SORT_RD;
         sks_pkg::S_SORT_SWAP_A: state_in = sks_pkg::S_SORT_SWAP_B;
         sks_pkg::S_SORT_SWAP_B: state_in = sks_pkg::S_SORT_OUTER;
         sks_pkg::S_SRCH_STEP: begin
            if (sts.bad_key || sts.empty) state_in = sks_pkg::S_RESP;
            else if (sts.srch_done)       state_in = sks_pkg::S_SRCH_CHK_R;
            else                          state_in = sks_pkg::S_SRCH_RD;
         end
         sks_pkg::S_SRCH_RD:    state_in = sks_pkg::S_SRCH_CMP;
         sks_pkg::S_SRCH_CMP:   state_in = sks_pkg::S_SRCH_STEP;
         sks_pkg::S_SRCH_CHK_R:
            state_in = sts.rd_match ? sks_pkg::S_RESP : sks_pkg::S_SRCH_CHK_L;
         sks_pkg::S_SRCH_CHK_L: state_in = sks_pkg::S_RESP;
         sks_pkg::S_RESP:
            if (!rsp_valid_ff || rsp_tready) state_in = sks_pkg::S_IDLE;
         default:               state_in = sks_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         sks_pkg::S_IDLE: begin
            req_tready    = 1'b1;
            cmd.load_req  = req_tvalid;
            cmd.sort_init = req_tvalid;
            cmd.srch_init = req_tvalid;
         end
         sks_pkg::S_PUSH: begin
            cmd.push_wr         = !sts.full;
            cmd.set_status_full = sts.full;
         end
         sks_pkg::S_SORT_OUTER: begin
            cmd.sort_outer  = !sts.outer_done;
            cmd.mark_sorted = sts.outer_done;
         end
         sks_pkg::S_SORT_RD:     cmd.sort_rd_j = 1'b1;
         sks_pkg::S_SORT_CMP:    cmd.sort_cmp  = 1'b1;
         sks_pkg::S_SORT_SWAP_A: cmd.swap_rd   = 1'b1;
         sks_pkg::S_SORT_SWAP_B: cmd.swap_wr   = 1'b1;
         sks_pkg::S_SRCH_STEP: begin
            cmd.set_status_bad = sts.bad_key;
            cmd.srch_miss      = !sts.bad_key && sts.empty;
            cmd.srch_rd_r      = !sts.bad_key && !sts.empty && sts.srch_done;
            cmd.srch_rd_mid    = !sts.bad_key && !sts.empty && !sts.srch_done;
         end
         sks_pkg::S_SRCH_RD:    cmd.srch_rd_mid = 1'b1;
         sks_pkg::S_SRCH_CMP:   cmd.srch_cmp = 1'b1;
         sks_pkg::S_SRCH_CHK_R: begin
            cmd.srch_hit  = sts.rd_match;
            cmd.srch_rd_l = !sts.rd_match;
         end
         sks_pkg::S_SRCH_CHK_L: begin
            cmd.srch_hit  = sts.rd_match;
            cmd.srch_miss = !sts.rd_match;
         end
         sks_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.resp_load = 1'b1;
               rsp_valid_in  = 1'b1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> state_ff == sks_pkg::S_IDLE)
      else $error("ready outside idle");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped");
   a_one_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second accept without response");

endmodule
`default_nettype wire

[design/sks_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sks_datapath
// Key and value memories, index registers, key compare and result register.
// ----------------------------------------------------------------------------
module sks_datapath #(
   parameter int KEY_CHARS   = sks_pkg::KEY_CHARS_DEF,
   parameter int VALUE_CHARS = sks_pkg::VALUE_CHARS_DEF,
   parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sks_pkg::OP_W-1:0]      req_op,
   input  wire logic [sks_pkg::KEY_W-1:0]     req_key,
   input  wire logic [sks_pkg::VALUE_W-1:0]   req_value,
   input  wire sks_pkg::cmd_type              cmd,
   output sks_pkg::sts_type                   sts,
   output logic [sks_pkg::STATUS_W-1:0]       rsp_status,
   output logic [sks_pkg::VALUE_W-1:0]        rsp_found_value,
   output logic [sks_pkg::COUNT_W-1:0]        rsp_entry_count,
   output logic                               rsp_table_sorted
);

   localparam int KW  = 8 * KEY_CHARS;
   localparam int VW  = 8 * VALUE_CHARS;
   localparam int AW  = $clog2(TABLE_DEPTH);
   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int OW  = sks_pkg::COUNT_W;

   logic [KW-1:0] key_mem [TABLE_DEPTH];
   logic [VW-1:0] val_mem [TABLE_DEPTH];

   logic [sks_pkg::OP_W-1:0] op_ff;
   logic [KW-1:0] key_ff, cut_key;
   logic [VW-1:0] val_ff;
   logic [CW-1:0] fill_ff, i_ff, j_ff, pick_ff, left_ff, right_ff, mid;
   logic          sorted_ff;
   logic [KW-1:0] min_ff, rd_key_ff, ki_ff;
   logic [VW-1:0] rd_val_ff, vi_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          wr_en;
   logic [KW-1:0] wr_key;
   logic [VW-1:0] wr_val;
   logic [sks_pkg::STATUS_W-1:0] status_ff;
   logic [VW-1:0] found_ff;
   logic          bad;
   logic [sks_pkg::STATUS_W-1:0] st_q;
   logic [sks_pkg::VALUE_W-1:0]  fv_q;
   logic [OW-1:0] cnt_q;
   logic          srt_q;

   always_comb begin
      logic cut;
      cut = 1'b0;
      bad = 1'b0;
      cut_key = key_ff;
      for (int b = KEY_CHARS - 1; b >= 0; b--) begin
         if (key_ff[8*b +: 8] == 8'd0) begin
            cut = 1'b1;
            bad = 1'b1;
         end
         if (cut) cut_key[8*b +: 8] = 8'd0;
      end
   end

   assign mid = CW'((({1'b0, left_ff} + {1'b0, right_ff}) >> 1));

   always_comb begin
      rd_addr = AW'(j_ff);
      if (cmd.srch_rd_mid)    rd_addr = AW'(mid);
      else if (cmd.srch_rd_r) rd_addr = AW'(right_ff);
      else if (cmd.srch_rd_l) rd_addr = AW'(left_ff);
      else if (cmd.swap_rd)   rd_addr = AW'(pick_ff);
      else if (cmd.sort_outer) rd_addr = AW'(i_ff);
      wr_en   = cmd.push_wr || cmd.swap_rd || cmd.swap_wr;
      wr_addr = AW'(fill_ff);
      wr_key  = cut_key;
      wr_val  = val_ff;
      if (cmd.swap_rd) begin
         wr_addr = AW'(pick_ff);
         wr_key  = ki_ff;
         wr_val  = vi_ff;
      end else if (cmd.swap_wr) begin
         wr_addr = AW'(i_ff);
         wr_key  = rd_key_ff;
         wr_val  = rd_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[rd_addr];
      rd_val_ff <= val_mem[rd_addr];
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         sorted_ff <= 1'b0;
      end else begin
         if (cmd.push_wr)     fill_ff   <= fill_ff + 1'b1;
         if (cmd.mark_sorted) sorted_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_op;
         key_ff    <= req_key[KW-1:0];
         val_ff    <= req_value[VW-1:0];
         status_ff <= sks_pkg::ST_OK;
         found_ff  <= '0;
      end
      if (cmd.sort_init) i_ff <= '0;
      if (cmd.srch_init) begin
         left_ff  <= '0;
         right_ff <= (fill_ff == '0) ? '0 : fill_ff - 1'b1;
      end
      if (cmd.sort_outer) begin
         j_ff    <= i_ff;
         pick_ff <= i_ff;
      end
      if (cmd.sort_rd_j) begin
         if (j_ff == i_ff) begin
            ki_ff  <= rd_key_ff;
            vi_ff  <= rd_val_ff;
            min_ff <= rd_key_ff;
         end
      end
      if (cmd.sort_cmp) begin
         if (rd_key_ff < min_ff) begin
            min_ff  <= rd_key_ff;
            pick_ff <= j_ff;
         end
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.swap_wr) i_ff <= i_ff + 1'b1;
      if (cmd.srch_cmp) begin
         if (rd_key_ff < key_ff) left_ff  <= mid;
         else                    right_ff <= mid;
      end
      if (cmd.set_status_full) status_ff <= sks_pkg::ST_FULL;
      if (cmd.set_status_bad)  status_ff <= sks_pkg::ST_BAD_KEY;
      if (cmd.srch_miss)       status_ff <= sks_pkg::ST_NOT_FOUND;
      if (cmd.srch_hit)        found_ff  <= rd_val_ff;
      if (cmd.resp_load) begin
         st_q  <= status_ff;
         fv_q  <= sks_pkg::VALUE_W'(found_ff);
         cnt_q <= OW'(fill_ff);
         srt_q <= sorted_ff;
      end
   end

   assign sts.op         = req_op;
   assign sts.full       = fill_ff >= CW'(TABLE_DEPTH);
   assign sts.empty      = fill_ff == '0;
   assign sts.bad_key    = bad && (op_ff == sks_pkg::OP_SEARCH);
   assign sts.outer_done = ({1'b0, i_ff} + 1'b1) >= {1'b0, fill_ff};
   assign sts.inner_done = (j_ff + 1'b1) >= fill_ff;
   assign sts.srch_done  = !(({1'b0, left_ff} + 1'b1) < {1'b0, right_ff});
   assign sts.rd_match   = rd_key_ff == key_ff;

   assign rsp_status       = st_q;
   assign rsp_found_value  = fv_q;
   assign rsp_entry_count  = cnt_q;
   assign rsp_table_sorted = srt_q;

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(TABLE_DEPTH))
      else $error("fill count past depth");
   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("push did not grow table");
   a_srch_order: assert property (@(posedge clock) disable iff (reset)
      cmd.srch_cmp |-> left_ff <= right_ff)
      else $error("search bounds crossed");

endmodule
`default_nettype wire

[design/sorted_key_table_search.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table_search
// Key/value table with push, selection sort and binary search.
//
// channel  dir  beat contents
// req      in   tdata: operation, key, value
// rsp      out  tdata: status, found_value, entry_count, table_sorted
//
// One item at a time. Search time grows with the probes of the table memory;
// sort time is set by one compare per memory read in the inner scan.
// Synchronous reset empties the table. A stalled response holds; a new beat
// is still accepted meanwhile, and its response is loaded once the response
// register is free.
// ----------------------------------------------------------------------------
module sorted_key_table_search #(
   parameter int KEY_CHARS   = sks_pkg::KEY_CHARS_DEF,
   parameter int VALUE_CHARS = sks_pkg::VALUE_CHARS_DEF,
   parameter int TABLE_DEPTH = sks_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [119:0] req_tdata,  // operation[1:0], key[49:2], value[113:50]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [79:0]       rsp_tdata   // status[1:0], found_value[65:2],
                                         // entry_count[72:66], table_sorted[73]
);

   sks_pkg::cmd_type cmd;
   sks_pkg::sts_type sts;
   logic [sks_pkg::STATUS_W-1:0] st;
   logic [sks_pkg::VALUE_W-1:0]  fv;
   logic [sks_pkg::COUNT_W-1:0]  cnt;
   logic                         srt;

   sks_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .sts, .cmd
   );

   sks_datapath #(
      .KEY_CHARS(KEY_CHARS), .VALUE_CHARS(VALUE_CHARS), .TABLE_DEPTH(TABLE_DEPTH)
   ) u_dp (
      .clock, .reset,
      .req_op(req_tdata[1:0]),
      .req_key(req_tdata[49:2]),
      .req_value(req_tdata[113:50]),
      .cmd, .sts,
      .rsp_status(st), .rsp_found_value(fv), .rsp_entry_count(cnt),
      .rsp_table_sorted(srt)
   );

   assign rsp_tdata = {6'd0, srt, cnt, fv, st};

endmodule
`default_nettype wire

[verif/tb_sorted_key_table_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_key_table_search
// Stream-level check of the key/value table. Push, sort and search beats are
// fed with random idling on both sides. A table model predicts status, found
// value, entry count and sorted mark for every beat. Each response is compared
// in order against the predicted queue.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_search;

   typedef struct packed {
      logic                           table_sorted;
      logic [sks_pkg::COUNT_W-1:0]    entry_count;
      logic [sks_pkg::VALUE_W-1:0]    found_value;
      logic [sks_pkg::STATUS_W-1:0]   status;
   } lookup_reply_type;

   class table_scoreboard;
      logic [sks_pkg::KEY_W-1:0]   keys[64];
      logic [sks_pkg::VALUE_W-1:0] vals[64];
      int unsigned        fill;
      bit                 sorted;
      lookup_reply_type   pending[$];
      int unsigned        errors;
      int unsigned        replies;
      int unsigned        hits;

      function void note_request(logic [sks_pkg::OP_W-1:0] op,
                                 logic [sks_pkg::KEY_W-1:0] key,
                                 logic [sks_pkg::VALUE_W-1:0] val);
         lookup_reply_type r;
         logic [sks_pkg::KEY_W-1:0] k, tk;
         logic [sks_pkg::VALUE_W-1:0] tv;
         bit cut, zero;
         int unsigned lo, hi, mid, pick;
         r = '0;
         if (op == sks_pkg::OP_PUSH) begin
            if (fill >= 64) begin
               r.status = sks_pkg::ST_FULL;
            end else begin
               k = key;
               cut = 0;
               for (int b = 5; b >= 0; b--) begin
                  if (k[b*8 +: 8] == 8'd0) cut = 1;
                  if (cut) k[b*8 +: 8] = 8'd0;
               end
               keys[fill] = k;
               vals[fill] = val;
               fill++;
            end
         end else if (op == sks_pkg::OP_SORT) begin
            for (int i = 0; i + 1 < fill; i++) begin
               pick = i;
               for (int j = i; j < fill; j++)
                  if (keys[j] < keys[pick]) pick = j;
               tk = keys[i]; tv = vals[i];
               keys[i] = keys[pick]; vals[i] = vals[pick];
               keys[pick] = tk; vals[pick] = tv;
            end
            sorted = 1;
         end else if (op == sks_pkg::OP_SEARCH) begin
            zero = 0;
            for (int b = 0; b < 6; b++)
               if (key[b*8 +: 8] == 8'd0) zero = 1;
            if (zero) begin
               r.status = sks_pkg::ST_BAD_KEY;
            end else if (fill == 0) begin
               r.status = sks_pkg::ST_NOT_FOUND;
            end else begin
               lo = 0;
               hi = fill - 1;
               while (lo + 1 < hi) begin
                  mid = (lo + hi) / 2;
                  if (keys[mid] < key) lo = mid;
                  else hi = mid;
               end
               if (keys[hi] == key) r.found_value = vals[hi];
               else if (keys[lo] == key) r.found_value = vals[lo];
               else r.status = sks_pkg::ST_NOT_FOUND;
               if (r.status == sks_pkg::ST_OK) hits++;
            end
         end
         r.entry_count = fill[sks_pkg::COUNT_W-1:0];
         r.table_sorted = sorted;
         pending.push_back(r);
      endfunction

      function void check_reply(lookup_reply_type got);
         lookup_reply_type want;
         replies++;
         if (pending.size() == 0) begin
            $error("unexpected response beat %h", got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
         end
         if (got.found_value !== want.found_value) begin
            $error("found_value expected %h actual %h", want.found_value, got.found_value);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count expected %0d actual %0d", want.entry_count,
                   got.entry_count);
            errors++;
         end
         if (got.table_sorted !== want.table_sorted) begin
            $error("table_sorted expected %0d actual %0d", want.table_sorted,
                   got.table_sorted);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [119:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [79:0]  rsp_tdata;

   table_scoreboard sb;
   int unsigned send_idle;
   int unsigned recv_stall;
   bit          hold_rsp;
   int unsigned hold_cycles;
   logic [sks_pkg::KEY_W-1:0] known_keys[$];

   sorted_key_table_search dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("== FAIL ==");
      $finish;
   end

   // receive side: random stall, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            sb.check_reply(lookup_reply_type'(rsp_tdata[73:0]));
         if (hold_rsp && hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   function automatic logic [sks_pkg::KEY_W-1:0] rand_key(bit allow_zero);
      logic [sks_pkg::KEY_W-1:0] k;
      for (int b = 0; b < 6; b++) begin
         k[b*8 +: 8] = 8'($urandom_range(255));
         if (!allow_zero && k[b*8 +: 8] == 0) k[b*8 +: 8] = 8'd1;
      end
      if (allow_zero && $urandom_range(3) == 0) k[$urandom_range(5)*8 +: 8] = 8'd0;
      return k;
   endfunction

   task automatic send_beat(logic [sks_pkg::OP_W-1:0] op,
                            logic [sks_pkg::KEY_W-1:0] key,
                            logic [sks_pkg::VALUE_W-1:0] val);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tdata  <= {6'd0, val, key, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(op, key, val);
      if (op == sks_pkg::OP_PUSH) known_keys.push_back(key);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   task automatic random_phase(int unsigned n);
      int unsigned sel;
      logic [sks_pkg::KEY_W-1:0] k;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (sel < 40) begin
            k = ($urandom_range(4) == 0 && known_keys.size() != 0) ?
                known_keys[$urandom_range(known_keys.size() - 1)] : rand_key(1);
            send_beat(sks_pkg::OP_PUSH, k, {$urandom, $urandom});
         end else if (sel < 44) begin
            send_beat(sks_pkg::OP_SORT, rand_key(1), {$urandom, $urandom});
         end else if (sel < 46) begin
            send_beat(sks_pkg::OP_NOP, rand_key(1), {$urandom, $urandom});
         end else begin
            k = ($urandom_range(2) != 0 && known_keys.size() != 0) ?
                known_keys[$urandom_range(known_keys.size() - 1)] : rand_key(1);
            send_beat(sks_pkg::OP_SEARCH, k, {$urandom, $urandom});
         end
         // probe with a clean key now and then once the table is near full
         if (sb.fill >= 60 && $urandom_range(9) == 0) begin
            send_beat(sks_pkg::OP_SEARCH, rand_key(0), '0);
         end
      end
   endtask

   initial begin
      sb = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      send_idle  = 0;
      recv_stall = 0;
      hold_rsp   = 0;
      hold_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, bad key, sort of empty, unused code
      send_beat(sks_pkg::OP_SEARCH, 48'h414243444546, '0);
      send_beat(sks_pkg::OP_SEARCH, 48'h410043444546, '0);
      send_beat(sks_pkg::OP_SORT, '0, '0);
      send_beat(sks_pkg::OP_NOP, '1, '1);
      send_beat(sks_pkg::OP_PUSH, 48'hFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF);
      send_beat(sks_pkg::OP_SEARCH, 48'hFFFFFFFFFFFF, '0);
      send_beat(sks_pkg::OP_PUSH, 48'h010101010101, 64'h0);
      send_beat(sks_pkg::OP_PUSH, 48'h5A5A00FFFFFF, 64'h0123456789ABCDEF);
      send_beat(sks_pkg::OP_PUSH, 48'h000000000000, 64'hAAAAAAAAAAAAAAAA);
      send_beat(sks_pkg::OP_PUSH, 48'h808080808080, 64'h5555555555555555);
      send_beat(sks_pkg::OP_PUSH, 48'h808080808080, 64'h1111111111111111);
      send_beat(sks_pkg::OP_SEARCH, 48'h010101010101, '0);
      send_beat(sks_pkg::OP_SORT, '0, '0);
      send_beat(sks_pkg::OP_SEARCH, 48'h808080808080, '0);
      send_beat(sks_pkg::OP_SEARCH, 48'h010101010101, '0);
      send_beat(sks_pkg::OP_SEARCH, 48'h000000000000, '0);
      send_beat(sks_pkg::OP_PUSH, 48'h7F7F7F7F7F7F, 64'h8000000000000001);
      send_beat(sks_pkg::OP_SEARCH, 48'h7F7F7F7F7F7F, '0);
      for (int i = 0; i < 60; i++)
         send_beat(sks_pkg::OP_PUSH, rand_key(0), {$urandom, $urandom});
      send_beat(sks_pkg::OP_PUSH, '1, '1);
      send_beat(sks_pkg::OP_SORT, '0, '0);
      send_beat(sks_pkg::OP_SEARCH, 48'hFFFFFFFFFFFF, '0);
      drain();

      // long hold-off on the response side while requests keep coming
      hold_cycles = 300;
      hold_rsp = 1;
      for (int i = 0; i < 6; i++) send_beat(sks_pkg::OP_SEARCH, rand_key(0), '0);
      hold_rsp = 0;
      drain();

      // duplicate-key search against the sorted full table
      random_phase(250);
      drain();
      send_idle = 86; recv_stall = 0;  random_phase(250);
      send_idle = 0;  recv_stall = 86; random_phase(250);
      send_idle = 34; recv_stall = 34; random_phase(250);
      send_idle = 0;  recv_stall = 0;  random_phase(150);
      drain();
      repeat (50) @(posedge clock);

      $display("ran %0d responses, %0d search hits, table ended with %0d entries",
               sb.replies, sb.hits, sb.fill);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[filelist.f]
design/sks_pkg.sv
design/sks_ctrl.sv
design/sks_datapath.sv
design/sorted_key_table_search.sv
verif/tb_sorted_key_table_search.sv
